// ===== design/lrk4_pkg.sv =====
package lrk4_pkg;

  localparam int unsigned FRAC_BITS_DEF = 24;

  // field widths
  localparam int unsigned STATE_W  = 32;
  localparam int unsigned STEP_W   = 25;
  localparam int unsigned COEF_W   = 31;
  localparam int unsigned OFF_W    = 25;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 32;

  // multiplier operands and accumulator of k1 + 2k2 + 2k3 + k4
  localparam int unsigned ACC_W  = 35;
  localparam int unsigned OPA_W  = 32;
  localparam int unsigned OPB_W  = ACC_W;
  localparam int unsigned PROD_W = OPA_W + OPB_W;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIGMA = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RHO   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BETA  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OFF   = 3'd5;

  // request types
  localparam logic REQ_STEP = 1'b0;
  localparam logic REQ_LOAD = 1'b1;

  // operation slots within one runge-kutta stage
  localparam logic [2:0] OP_DX   = 3'd0;
  localparam logic [2:0] OP_DY   = 3'd1;
  localparam logic [2:0] OP_XY   = 3'd2;
  localparam logic [2:0] OP_DZ   = 3'd3;
  localparam logic [2:0] OP_LAST = 3'd6;
  localparam logic [1:0] STAGE_HALF2 = 2'd1;
  localparam logic [1:0] STAGE_FULL  = 2'd2;
  localparam logic [1:0] STAGE_LAST  = 2'd3;

  // divide by six, one byte per cycle: floor(v / 6) = (v * 2731) >> 14 for v < 1536
  localparam int unsigned DIG_W   = 8;
  localparam int unsigned REM_W   = 3;
  localparam int unsigned DV_W    = DIG_W + REM_W;
  localparam int unsigned RCP_W   = 12;
  localparam logic [RCP_W-1:0] RECIP6 = 12'd2731;
  localparam int unsigned RECIP_SH = 14;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_RUN   = 6'b000010,
    ST_DRAIN = 6'b000100,
    ST_DIV   = 6'b001000,
    ST_WB    = 6'b010000,
    ST_FIN   = 6'b100000
  } state_e;

endpackage

// ===== design/lorenz_rk4_integrator_top.sv =====
// step request: the /6 runs over NB = ceil((63 - FRAC_BITS) / 8) quotient bytes; a new request
// is accepted only once the result has been posted
// a step runs 28 operations through one shared 32x35 multiplier, then a byte-serial /6
// load request: the loaded state is posted as the result, with no arithmetic
// reset: state x, y, z = 1.0, registers to their defaults, no clearing pass
module lorenz_rk4_integrator_top import lrk4_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        req_type_i,
  input  logic signed [STATE_W-1:0]   load_x_i,
  input  logic signed [STATE_W-1:0]   load_y_i,
  input  logic signed [STATE_W-1:0]   load_z_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [STATE_W-1:0]   out_x_o,
  output logic signed [STATE_W-1:0]   out_y_o,
  output logic signed [STATE_W-1:0]   out_z_o,
  output logic                        saturated_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [CFG_DAT_W-1:0]        cfg_data_i
);

  localparam int unsigned SW = PROD_W + 3;
  localparam int unsigned RW = PROD_W + 1 - FRAC_BITS;
  localparam int unsigned TW = STEP_W + ACC_W + 1 - FRAC_BITS;
  localparam int unsigned UW = TW + 2;
  localparam int unsigned NB = (UW + DIG_W - 1) / DIG_W;
  localparam int unsigned QW = NB * DIG_W;
  localparam int unsigned CW = $clog2(NB);

  localparam logic [63:0] ONE_FX = 64'd1 << FRAC_BITS;
  localparam logic [STEP_W-1:0] STEP_RST  = STEP_W'((ONE_FX + 64'd50) / 64'd100);
  localparam logic [COEF_W-1:0] SIGMA_RST = COEF_W'(ONE_FX * 64'd10);
  localparam logic [COEF_W-1:0] RHO_RST   = COEF_W'(ONE_FX * 64'd28);
  localparam logic [COEF_W-1:0] BETA_RST  = COEF_W'((ONE_FX * 64'd8 + 64'd1) / 64'd3);
  localparam logic [OFF_W-1:0]  OFF_RST   = OFF_W'((ONE_FX + 64'd600) / 64'd1200);
  localparam logic signed [STATE_W-1:0] POS_RST = STATE_W'(ONE_FX);

  localparam logic signed [SW-1:0] RND_HALF = SW'(64'd1 << (FRAC_BITS - 1));
  localparam logic signed [SW-1:0] RND_PT   = SW'(ONE_FX);
  localparam logic signed [SW-1:0] RND_UPD  = SW'(64'd3 << FRAC_BITS);
  localparam logic signed [SW-1:0] Q_OFF    = SW'(64'd1 << (TW - 1));
  localparam logic [QW-1:0]        U_BIAS   = QW'(64'd3 << TW);
  localparam logic signed [SW-1:0] S32_MAX  = SW'(64'h7fff_ffff);
  localparam logic signed [SW-1:0] S32_MIN  = -SW'(64'h8000_0000);

  function automatic logic signed [STATE_W-1:0] sat32(input logic signed [SW-1:0] v);
    logic signed [STATE_W-1:0] r;
    if (v > S32_MAX) begin
      r = STATE_W'(S32_MAX);
    end else if (v < S32_MIN) begin
      r = STATE_W'(S32_MIN);
    end else begin
      r = STATE_W'(v);
    end
    return r;
  endfunction

  function automatic logic clip32(input logic signed [SW-1:0] v);
    return (v > S32_MAX) || (v < S32_MIN);
  endfunction

  // configuration
  logic                mode_q;
  logic [STEP_W-1:0]   step_q;
  logic [COEF_W-1:0]   sigma_q, rho_q, beta_q;
  logic [OFF_W-1:0]    off_q;

  // control
  state_e              state_q, state_d;
  logic [1:0]          stage_q, stage_d;
  logic [2:0]          sub_q, sub_d;
  logic                pv_q;
  logic [1:0]          ps_q;
  logic [2:0]          pm_q;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic                clip_q;
  logic                out_valid_q;

  // datapath
  logic signed [STATE_W-1:0] pos_q [3];
  logic signed [STATE_W-1:0] pt_q  [3];
  logic signed [STATE_W-1:0] k_q   [3];
  logic signed [ACC_W-1:0]   acc_q [3];
  logic signed [RW-1:0]      tmp_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic [QW-1:0]             u_q   [3];
  logic [REM_W-1:0]          rem_q [3];

  logic in_fire, fin_fire, run_last;
  logic [1:0] lane, plane;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i & in_ready_o;
  assign fin_fire    = (state_q == ST_FIN) & (~out_valid_q | out_ready_i);
  assign run_last    = (stage_q == STAGE_LAST) && (sub_q == OP_LAST);
  assign lane        = sub_q[1:0];
  assign plane       = pm_q[1:0];

  // operand selection for the shared multiplier
  logic signed [STATE_W-1:0] diff_yx, rho_mz;
  logic signed [OPA_W-1:0]   opa;
  logic signed [OPB_W-1:0]   opb;

  assign diff_yx = sat32(SW'(pt_q[1]) - SW'(pt_q[0]));
  assign rho_mz  = sat32(signed'(SW'(rho_q)) - SW'(pt_q[2]));

  always_comb begin
    case (sub_q)
      OP_DX: begin
        opa = signed'(OPA_W'(sigma_q));
        opb = OPB_W'(diff_yx);
      end
      OP_DY: begin
        opa = pt_q[0];
        opb = OPB_W'(rho_mz);
      end
      OP_XY: begin
        opa = pt_q[0];
        opb = OPB_W'(pt_q[1]);
      end
      OP_DZ: begin
        opa = signed'(OPA_W'(beta_q));
        opb = OPB_W'(pt_q[2]);
      end
      default: begin
        opa = signed'(OPA_W'(step_q));
        opb = (stage_q == STAGE_LAST) ? acc_q[lane] : OPB_W'(k_q[lane]);
      end
    endcase
  end

  // result handling on the registered product, in the cycle after the multiply
  logic signed [SW-1:0] p_ext, rnd, rnd_pt, upd, off_sel, kval_w;
  logic signed [STATE_W-1:0] kval;
  logic [1:0] klane;
  logic       kwr, w2;

  assign p_ext   = SW'(prod_q);
  assign rnd     = (p_ext + RND_HALF) >>> FRAC_BITS;
  assign rnd_pt  = (p_ext + RND_PT) >>> (FRAC_BITS + 1);
  assign upd     = (p_ext + RND_UPD) >>> FRAC_BITS;
  assign off_sel = mode_q ? signed'(SW'(off_q)) : '0;
  assign w2      = ps_q[0] ^ ps_q[1];

  always_comb begin
    kval_w = rnd;
    klane  = 2'd0;
    kwr    = 1'b0;
    case (pm_q)
      OP_DX: begin
        kval_w = rnd;
        klane  = 2'd0;
        kwr    = pv_q;
      end
      OP_DY: begin
        kval_w = rnd - SW'(pt_q[1]) - off_sel;
        klane  = 2'd1;
        kwr    = pv_q;
      end
      OP_DZ: begin
        kval_w = SW'(tmp_q) - rnd;
        klane  = 2'd2;
        kwr    = pv_q;
      end
      default: begin
        kwr = 1'b0;
      end
    endcase
  end

  assign kval = sat32(kval_w);

  // byte-serial divide by six, three lanes
  logic [DV_W-1:0]        dv   [3];
  logic [DV_W+RCP_W-1:0]  dprd [3];
  logic [DIG_W-1:0]       dig  [3];
  logic [REM_W-1:0]       drem [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dv[i]   = {rem_q[i], u_q[i][QW-1 -: DIG_W]};
      dprd[i] = (DV_W + RCP_W)'(dv[i]) * (DV_W + RCP_W)'(RECIP6);
      dig[i]  = DIG_W'(dprd[i] >> RECIP_SH);
      drem[i] = REM_W'(dv[i] - DV_W'(dig[i]) * DV_W'(6));
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    stage_d = stage_q;
    sub_d   = sub_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          stage_d = '0;
          sub_d   = '0;
          state_d = (req_type_i == REQ_LOAD) ? ST_FIN : ST_RUN;
        end
      end
      ST_RUN: begin
        if (run_last) begin
          state_d = ST_DRAIN;
        end else if (sub_q == OP_LAST) begin
          sub_d   = '0;
          stage_d = stage_q + 2'd1;
        end else begin
          sub_d = sub_q + 3'd1;
        end
      end
      ST_DRAIN: begin
        cnt_d   = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CW'(NB - 1)) begin
          state_d = ST_WB;
        end
      end
      ST_WB: begin
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (fin_fire) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      stage_q     <= '0;
      sub_q       <= '0;
      cnt_q       <= '0;
      pv_q        <= 1'b0;
      ps_q        <= '0;
      pm_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      stage_q <= stage_d;
      sub_q   <= sub_d;
      cnt_q   <= cnt_d;
      pv_q    <= (state_q == ST_RUN);
      ps_q    <= stage_q;
      pm_q    <= sub_q;
      if (fin_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      step_q  <= STEP_RST;
      sigma_q <= SIGMA_RST;
      rho_q   <= RHO_RST;
      beta_q  <= BETA_RST;
      off_q   <= OFF_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_MODE:  mode_q  <= cfg_data_i[0];
        REG_STEP:  step_q  <= cfg_data_i[STEP_W-1:0];
        REG_SIGMA: sigma_q <= cfg_data_i[COEF_W-1:0];
        REG_RHO:   rho_q   <= cfg_data_i[COEF_W-1:0];
        REG_BETA:  beta_q  <= cfg_data_i[COEF_W-1:0];
        REG_OFF:   off_q   <= cfg_data_i[OFF_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // architectural state and clip flag
  logic signed [SW-1:0] new_pos [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      new_pos[i] = SW'(pos_q[i]) + signed'(SW'(u_q[i])) - Q_OFF;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        pos_q[i] <= POS_RST;
      end
      clip_q <= 1'b0;
    end else if (in_fire) begin
      clip_q <= 1'b0;
      if (req_type_i == REQ_LOAD) begin
        pos_q[0] <= load_x_i;
        pos_q[1] <= load_y_i;
        pos_q[2] <= load_z_i;
      end
    end else if (state_q == ST_WB) begin
      for (int i = 0; i < 3; i++) begin
        pos_q[i] <= sat32(new_pos[i]);
      end
      clip_q <= clip32(new_pos[0]) | clip32(new_pos[1]) | clip32(new_pos[2]);
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    prod_q <= opa * opb;

    if (in_fire) begin
      for (int i = 0; i < 3; i++) begin
        pt_q[i]  <= pos_q[i];
        acc_q[i] <= '0;
      end
    end else if (pv_q) begin
      if (kwr) begin
        k_q[klane]   <= kval;
        acc_q[klane] <= acc_q[klane] + (w2 ? (ACC_W'(kval) <<< 1) : ACC_W'(kval));
      end
      if (pm_q == OP_XY) begin
        tmp_q <= RW'(rnd);
      end
      if (pm_q > OP_DZ) begin
        if (ps_q == STAGE_LAST) begin
          u_q[plane] <= QW'(upd) + U_BIAS;
        end else begin
          pt_q[plane] <= sat32(SW'(pos_q[plane]) + ((ps_q == STAGE_FULL) ? rnd : rnd_pt));
        end
      end
    end

    if (state_q == ST_DRAIN) begin
      for (int i = 0; i < 3; i++) begin
        rem_q[i] <= '0;
      end
    end else if (state_q == ST_DIV) begin
      for (int i = 0; i < 3; i++) begin
        u_q[i]   <= {u_q[i][QW-DIG_W-1:0], dig[i]};
        rem_q[i] <= drem[i];
      end
    end

    if (fin_fire) begin
      out_x_o     <= pos_q[0];
      out_y_o     <= pos_q[1];
      out_z_o     <= pos_q[2];
      saturated_o <= clip_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== bench/lorenz_step_checker.sv =====
module lorenz_step_checker import lrk4_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  logic                        req_type_i,
  input  logic signed [STATE_W-1:0]   load_x_i,
  input  logic signed [STATE_W-1:0]   load_y_i,
  input  logic signed [STATE_W-1:0]   load_z_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  logic signed [STATE_W-1:0]   out_x_i,
  input  logic signed [STATE_W-1:0]   out_y_i,
  input  logic signed [STATE_W-1:0]   out_z_i,
  input  logic                        saturated_i,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [CFG_DAT_W-1:0]        cfg_data_i,
  output int unsigned                 err_count_o,
  output int unsigned                 pending_o
);

  localparam longint UNIT    = longint'(1) << FRAC_BITS;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;

  typedef struct packed {
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] z;
  } slope_t;

  typedef struct packed {
    logic signed [STATE_W-1:0] x;
    logic signed [STATE_W-1:0] y;
    logic signed [STATE_W-1:0] z;
    logic                      sat;
  } state_word_t;

  logic                      mode_q;
  logic [STEP_W-1:0]         dt_q;
  logic [COEF_W-1:0]         sigma_q;
  logic [COEF_W-1:0]         rho_q;
  logic [COEF_W-1:0]         beta_q;
  logic [OFF_W-1:0]          off_q;
  logic signed [STATE_W-1:0] px_q;
  logic signed [STATE_W-1:0] py_q;
  logic signed [STATE_W-1:0] pz_q;
  state_word_t               due_q[$];

  function automatic longint clamp32(longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  function automatic longint div_floor(longint n, longint d);
    if (n >= 0) return n / d;
    return -((-n + d - 1) / d);
  endfunction

  // half rounds towards plus infinity
  function automatic longint div_round(longint n, longint d);
    return div_floor(n + d / 2, d);
  endfunction

  function automatic longint qmul(longint a, longint b);
    return div_round(a * b, UNIT);
  endfunction

  function automatic slope_t lorenz_slope(longint x, longint y, longint z);
    slope_t d;
    longint dyv;
    d.x = clamp32(qmul(longint'(sigma_q), clamp32(y - x)));
    dyv = qmul(x, clamp32(longint'(rho_q) - z)) - y;
    if (mode_q) dyv -= longint'(off_q);
    d.y = clamp32(dyv);
    d.z = clamp32(qmul(x, y) - qmul(longint'(beta_q), z));
    return d;
  endfunction

  function automatic longint nudge(longint s, longint k, longint den);
    return clamp32(s + div_round(longint'(dt_q) * k, den));
  endfunction

  function automatic state_word_t rk4_advance();
    slope_t      k1, k2, k3, k4;
    longint      px, py, pz, nx, ny, nz;
    state_word_t r;
    px = px_q;
    py = py_q;
    pz = pz_q;
    k1 = lorenz_slope(px, py, pz);
    k2 = lorenz_slope(nudge(px, k1.x, 2 * UNIT), nudge(py, k1.y, 2 * UNIT),
                      nudge(pz, k1.z, 2 * UNIT));
    k3 = lorenz_slope(nudge(px, k2.x, 2 * UNIT), nudge(py, k2.y, 2 * UNIT),
                      nudge(pz, k2.z, 2 * UNIT));
    k4 = lorenz_slope(nudge(px, k3.x, UNIT), nudge(py, k3.y, UNIT), nudge(pz, k3.z, UNIT));
    nx = px + div_round(longint'(dt_q) * (k1.x + 2 * k2.x + 2 * k3.x + k4.x), 6 * UNIT);
    ny = py + div_round(longint'(dt_q) * (k1.y + 2 * k2.y + 2 * k3.y + k4.y), 6 * UNIT);
    nz = pz + div_round(longint'(dt_q) * (k1.z + 2 * k2.z + 2 * k3.z + k4.z), 6 * UNIT);
    r.sat = (nx != clamp32(nx)) || (ny != clamp32(ny)) || (nz != clamp32(nz));
    r.x = STATE_W'(clamp32(nx));
    r.y = STATE_W'(clamp32(ny));
    r.z = STATE_W'(clamp32(nz));
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    state_word_t got;
    state_word_t want;
    if (!rst_ni) begin
      mode_q      <= 1'b0;
      dt_q        <= STEP_W'((UNIT + 50) / 100);
      sigma_q     <= COEF_W'(10 * UNIT);
      rho_q       <= COEF_W'(28 * UNIT);
      beta_q      <= COEF_W'((8 * UNIT + 1) / 3);
      off_q       <= OFF_W'((UNIT + 600) / 1200);
      px_q        <= STATE_W'(UNIT);
      py_q        <= STATE_W'(UNIT);
      pz_q        <= STATE_W'(UNIT);
      err_count_o <= 0;
      pending_o   <= 0;
      due_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        got.x   = out_x_i;
        got.y   = out_y_i;
        got.z   = out_z_i;
        got.sat = saturated_i;
        if (due_q.size() == 0) begin
          if (err_count_o < 10) begin
            $display("unexpected state word x=%0d y=%0d z=%0d sat=%0b",
                     got.x, got.y, got.z, got.sat);
          end
          err_count_o <= err_count_o + 1;
        end else begin
          want = due_q.pop_front();
          if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
              got.sat !== want.sat) begin
            if (err_count_o < 10) begin
              $display("state mismatch: expected x=%0d y=%0d z=%0d sat=%0b, got x=%0d y=%0d z=%0d sat=%0b",
                       want.x, want.y, want.z, want.sat, got.x, got.y, got.z, got.sat);
            end
            err_count_o <= err_count_o + 1;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_MODE:  mode_q  <= cfg_data_i[0];
          REG_STEP:  dt_q    <= cfg_data_i[STEP_W-1:0];
          REG_SIGMA: sigma_q <= cfg_data_i[COEF_W-1:0];
          REG_RHO:   rho_q   <= cfg_data_i[COEF_W-1:0];
          REG_BETA:  beta_q  <= cfg_data_i[COEF_W-1:0];
          REG_OFF:   off_q   <= cfg_data_i[OFF_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        if (req_type_i == REQ_LOAD) begin
          want.x   = load_x_i;
          want.y   = load_y_i;
          want.z   = load_z_i;
          want.sat = 1'b0;
        end else begin
          want = rk4_advance();
        end
        px_q <= want.x;
        py_q <= want.y;
        pz_q <= want.z;
        due_q.push_back(want);
      end
      pending_o <= due_q.size();
    end
  end

endmodule

// ===== bench/testbench.sv =====
module testbench;
  import lrk4_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam logic signed [STATE_W-1:0] Q_MAX = 32'sh7FFFFFFF;
  localparam logic signed [STATE_W-1:0] Q_MIN = 32'sh80000000;
  localparam logic signed [STATE_W-1:0] Q_ONE = 32'sh01000000;

  localparam int unsigned STEP_TOP  = 16777216;
  localparam int unsigned COEF_TOP  = 2147483647;
  localparam int unsigned COEF_MID  = 1073741824;
  localparam int unsigned OFF_TOP   = 16777216;
  localparam int unsigned DT_DEF    = 167772;
  localparam int unsigned SIGMA_DEF = 167772160;
  localparam int unsigned RHO_DEF   = 469762048;
  localparam int unsigned BETA_DEF  = 44739243;
  localparam int unsigned OFF_DEF   = 13981;

  localparam int          ATTR_SPAN = 1677721600;
  localparam int          ATTR_HALF = 838860800;
  localparam int unsigned WATCHDOG_LIMIT = 4000;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic                      req_type;
  logic signed [STATE_W-1:0] load_x;
  logic signed [STATE_W-1:0] load_y;
  logic signed [STATE_W-1:0] load_z;
  logic                      out_valid;
  logic                      out_ready;
  logic signed [STATE_W-1:0] out_x;
  logic signed [STATE_W-1:0] out_y;
  logic signed [STATE_W-1:0] out_z;
  logic                      saturated;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [CFG_DAT_W-1:0]      cfg_data;
  int unsigned               err_count;
  int unsigned               pending;
  int unsigned               send_gap_pct;
  int unsigned               recv_gap_pct;
  int unsigned               n_sent;
  int unsigned               quiet;

  lorenz_rk4_integrator_top u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .req_type_i  (req_type),
    .load_x_i    (load_x),
    .load_y_i    (load_y),
    .load_z_i    (load_z),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_x_o     (out_x),
    .out_y_o     (out_y),
    .out_z_o     (out_z),
    .saturated_o (saturated),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  lorenz_step_checker u_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .req_type_i  (req_type),
    .load_x_i    (load_x),
    .load_y_i    (load_y),
    .load_z_i    (load_z),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_x_i     (out_x),
    .out_y_i     (out_y),
    .out_z_i     (out_z),
    .saturated_i (saturated),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .err_count_o (err_count),
    .pending_o   (pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_gap_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // valid is left high on return, the next call holds or drops it
  task automatic send_req(input logic kind, input logic signed [STATE_W-1:0] lx,
                          input logic signed [STATE_W-1:0] ly,
                          input logic signed [STATE_W-1:0] lz);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    load_x   <= lx;
    load_y   <= ly;
    load_z   <= lz;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    n_sent++;
    if (n_sent == 600) begin
      send_gap_pct = 79;
      recv_gap_pct = 7;
    end else if (n_sent == 1200) begin
      send_gap_pct = 0;
      recv_gap_pct = 0;
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic set_regs(input logic m, input int unsigned dt, input int unsigned sigma,
                          input int unsigned rho, input int unsigned beta,
                          input int unsigned off);
    settle();
    write_reg(REG_MODE, CFG_DAT_W'(m));
    write_reg(REG_STEP, dt);
    write_reg(REG_SIGMA, sigma);
    write_reg(REG_RHO, rho);
    write_reg(REG_BETA, beta);
    write_reg(REG_OFF, off);
    write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, $urandom);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [STATE_W-1:0] pick_coord();
    int unsigned r;
    r = $urandom_range(9);
    if (r < 5) return STATE_W'(int'($urandom_range(ATTR_SPAN)) - ATTR_HALF);
    if (r < 8) return $urandom;
    case ($urandom_range(4))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return '0;
      3: return '1;
      default: return Q_ONE;
    endcase
  endfunction

  task automatic run_segment(input int unsigned n, input int unsigned load_pct);
    repeat (n) begin
      if ($urandom_range(99) < load_pct) begin
        send_req(REQ_LOAD, pick_coord(), pick_coord(), pick_coord());
      end else begin
        send_req(REQ_STEP, $urandom, $urandom, $urandom);
      end
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    req_type     = REQ_STEP;
    load_x       = '0;
    load_y       = '0;
    load_z       = '0;
    out_ready    = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = REG_MODE;
    cfg_data     = '0;
    send_gap_pct = 7;
    recv_gap_pct = 79;
    n_sent       = 0;
    quiet        = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // from the reset state, then loads, mostly of extreme values, with a step after each
    repeat (3) send_req(REQ_STEP, $urandom, $urandom, $urandom);
    send_req(REQ_LOAD, Q_MAX, Q_MIN, '0);
    send_req(REQ_STEP, '1, '1, '1);
    send_req(REQ_LOAD, Q_MIN, Q_MIN, Q_MIN);
    send_req(REQ_STEP, '0, '0, '0);
    send_req(REQ_LOAD, Q_MAX, Q_MAX, Q_MAX);
    send_req(REQ_STEP, Q_MAX, Q_MIN, Q_MAX);
    send_req(REQ_LOAD, '0, '0, '0);
    send_req(REQ_STEP, $urandom, $urandom, $urandom);
    send_req(REQ_LOAD, '1, Q_ONE, '1);
    send_req(REQ_STEP, $urandom, $urandom, $urandom);
    send_req(REQ_LOAD, -32'sd134217728, 32'sd117440512, 32'sd452984832);
    repeat (3) send_req(REQ_STEP, $urandom, $urandom, $urandom);
    send_req(REQ_LOAD, Q_MAX, Q_MIN, Q_MAX);
    send_req(REQ_STEP, $urandom, $urandom, $urandom);
    send_req(REQ_LOAD, Q_MIN, Q_MAX, Q_MIN);
    send_req(REQ_STEP, $urandom, $urandom, $urandom);

    set_regs(1'b1, DT_DEF, SIGMA_DEF, RHO_DEF, BETA_DEF, OFF_DEF);
    run_segment(300, 8);
    set_regs(1'b0, STEP_TOP, SIGMA_DEF, RHO_DEF, BETA_DEF, 0);
    run_segment(150, 25);
    set_regs(1'b1, 0, COEF_TOP, COEF_TOP, COEF_TOP, OFF_TOP);
    run_segment(100, 20);
    set_regs(1'b1, 1, 0, 0, 0, 0);
    run_segment(100, 20);
    repeat (3) begin
      set_regs(1'($urandom_range(1)), $urandom_range(1 << 20), $urandom_range(COEF_MID),
               $urandom_range(COEF_MID), $urandom_range(COEF_MID), $urandom_range(OFF_TOP));
      run_segment(150, 12);
    end
    set_regs(1'($urandom_range(1)), $urandom_range(STEP_TOP), $urandom_range(COEF_TOP),
             $urandom_range(COEF_TOP), $urandom_range(COEF_TOP), $urandom_range(OFF_TOP));
    run_segment(150, 25);
    set_regs(1'b0, DT_DEF, SIGMA_DEF, RHO_DEF, BETA_DEF, OFF_DEF);
    run_segment(480, 5);

    settle();
    repeat (40) @(negedge clk);
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
